FILE: rtl/rau_pkg.sv
// rau_pkg: types and constants shared by the rational arithmetic unit
// depends on nothing
package rau_pkg;

  localparam int WIDTH = 16;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_ABS = 3'd4,
    OP_POW = 3'd5
  } rau_op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } rau_status_t;

  typedef enum logic [1:0] {
    CLS_ARITH,
    CLS_ABS,
    CLS_POW,
    CLS_NONE
  } rau_cls_t;

  typedef struct packed {
    rau_cls_t            cls;
    logic [2:0]          op;
    logic signed [15:0]  a_num;
    logic signed [15:0]  a_den;
    logic signed [15:0]  b_num;
    logic signed [15:0]  b_den;
    logic signed [7:0]   exponent;
  } rau_entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_NORM,
    B_GCD,
    B_DIV,
    B_PREP,
    B_POW,
    B_CHECK,
    B_EMIT
  } rau_bstate_t;

endpackage

FILE: rtl/rau_if.sv
// rau_if: valid/ready channels for operand items and results
// depends on nothing
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [15:0] a_num;
  logic signed [15:0] a_den;
  logic signed [15:0] b_num;
  logic signed [15:0] b_den;
  logic signed [7:0]  exponent;
  modport source (output valid, op, a_num, a_den, b_num, b_den, exponent, input ready);
  modport sink (input valid, op, a_num, a_den, b_num, b_den, exponent, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] res_num;
  logic [14:0]        res_den;
  logic [1:0]         status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface

FILE: rtl/rational_arith_unit.sv
// rational_arith_unit: signed fraction add, subtract, multiply, divide, absolute
// value and integer power, each result reduced by its gcd with a status code
// arithmetic ops form products, then reduce by binary gcd steps and restoring
// division; power runs the reduction twice plus one multiply step per unit of
// |exponent|; one item is executed at a time, a two-entry queue takes items ahead
// synchronous active-high reset empties the queue and the result register
module rational_arith_unit (
  input logic       clk,
  input logic       rst,
  rau_in_if.sink    req,
  rau_out_if.source rsp
);
  import rau_pkg::*;

  rau_entry_t push_data;
  rau_entry_t pop_data;
  logic       push;
  logic       full;
  logic       pop;
  logic       avail;

  rau_front u_front (
    .req   (req),
    .full  (full),
    .push  (push),
    .entry (push_data)
  );

  rau_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  rau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (avail),
    .ent_in (pop_data),
    .pop    (pop),
    .rsp    (rsp)
  );

endmodule

FILE: rtl/rau_front.sv
// rau_front: takes operand transfers and classifies them by opcode
// depends on rau_pkg and rau_if
module rau_front (
  rau_in_if.sink          req,
  input  logic            full,
  output logic            push,
  output rau_pkg::rau_entry_t entry
);
  import rau_pkg::*;

  rau_cls_t cls;

  always_comb begin
    unique case (req.op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: cls = CLS_ARITH;
      OP_ABS:                         cls = CLS_ABS;
      OP_POW:                         cls = CLS_POW;
      default:                        cls = CLS_NONE;
    endcase
  end

  assign req.ready = !full;
  assign push      = req.valid && !full;

  assign entry = '{cls: cls, op: req.op, a_num: req.a_num, a_den: req.a_den,
                   b_num: req.b_num, b_den: req.b_den, exponent: req.exponent};

endmodule

FILE: rtl/rau_queue.sv
// rau_queue: two-entry queue between the classifier and the execution sequencer
// depends on rau_pkg
module rau_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rau_pkg::rau_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                avail,
  output rau_pkg::rau_entry_t pop_data
);
  import rau_pkg::*;

  rau_entry_t slots [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'(QDEPTH));
  assign avail    = (count != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/rau_back.sv
// rau_back: sequencer that forms products, reduces by binary gcd and
// restoring division, raises powers and holds the result register
// depends on rau_pkg and rau_if
module rau_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  rau_pkg::rau_entry_t ent_in,
  output logic                pop,
  rau_out_if.source           rsp
);
  import rau_pkg::*;

  localparam logic [31:0] LIM = 32'(1) << (WIDTH - 1);

  rau_bstate_t state;
  rau_bstate_t state_next;

  rau_entry_t         ent;
  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [32:0] n;
  logic signed [32:0] d;
  logic               neg;
  logic               pow_pre;
  logic [31:0]        gx;
  logic [31:0]        gy;
  logic [4:0]         gsh;
  logic [31:0]        gdiv;
  logic [31:0]        qn;
  logic [31:0]        qd;
  logic [31:0]        rem_n;
  logic [31:0]        rem_d;
  logic [4:0]         cnt;
  logic [15:0]        base_n;
  logic [15:0]        base_d;
  logic [31:0]        pw_n;
  logic [31:0]        pw_d;
  logic [7:0]         pcnt;
  logic signed [15:0] res_num;
  logic [14:0]        res_den;
  rau_status_t        status;
  logic               o_valid;

  logic               gcd_done;
  logic [31:0]        g;
  logic [32:0]        sh_n;
  logic [32:0]        sh_d;
  logic               pow_over;
  logic [7:0]         kmag;
  logic               emit_go;
  logic               pow_quick;
  logic signed [15:0] mop0;
  logic signed [15:0] mop2;

  assign gcd_done  = (gx == 32'd0) || (gy == 32'd0);
  assign g         = (gx | gy) << gsh;
  assign sh_n      = {rem_n, qn[31]};
  assign sh_d      = {rem_d, qd[31]};
  assign pow_over  = (pw_n > LIM) || (pw_d > LIM);
  assign kmag      = ent.exponent[7] ? 8'(-ent.exponent) : 8'(ent.exponent);
  assign emit_go   = !o_valid || rsp.ready;
  assign pow_quick = (ent_in.a_den == 16'sd0) || (ent_in.exponent == 8'sd0) ||
                     (ent_in.a_num == 16'sd0);
  assign mop0      = (ent.op == OP_MUL) ? ent.b_num : ent.b_den;
  assign mop2      = (ent.op == OP_DIV) ? ent.b_num : ent.b_den;

  assign pop         = (state == B_IDLE) && avail;
  assign rsp.valid   = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (avail) begin
          unique case (ent_in.cls)
            CLS_ARITH: state_next = B_MUL;
            CLS_ABS:   state_next = B_NORM;
            CLS_POW:   state_next = pow_quick ? B_EMIT : B_GCD;
            CLS_NONE:  state_next = B_EMIT;
          endcase
        end
      end
      B_MUL:   state_next = B_SUM;
      B_SUM:   state_next = B_NORM;
      B_NORM:  state_next = (d == 33'sd0 || n == 33'sd0) ? B_EMIT : B_GCD;
      B_GCD:   if (gcd_done) state_next = B_DIV;
      B_DIV:   if (cnt == 5'd0) state_next = pow_pre ? B_PREP : B_CHECK;
      B_PREP:  state_next = B_POW;
      B_POW: begin
        if (pow_over) begin
          state_next = B_EMIT;
        end else if (pcnt == 8'd0) begin
          state_next = B_NORM;
        end
      end
      B_CHECK: state_next = B_EMIT;
      B_EMIT:  if (emit_go) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // datapath, advanced by the sequencer state
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        ent     <= ent_in;
        pow_pre <= 1'b0;
        if (avail) begin
          unique case (ent_in.cls)
            CLS_ABS: begin
              n <= ent_in.a_num[15] ? -33'(ent_in.a_num) : 33'(ent_in.a_num);
              d <= ent_in.a_den[15] ? -33'(ent_in.a_den) : 33'(ent_in.a_den);
            end
            CLS_POW: begin
              pow_pre <= 1'b1;
              neg     <= ent_in.a_num[15] ^ ent_in.a_den[15];
              gx      <= ent_in.a_num[15] ? 32'(-33'(ent_in.a_num)) : 32'(ent_in.a_num);
              gy      <= ent_in.a_den[15] ? 32'(-33'(ent_in.a_den)) : 32'(ent_in.a_den);
              qn      <= ent_in.a_num[15] ? 32'(-33'(ent_in.a_num)) : 32'(ent_in.a_num);
              qd      <= ent_in.a_den[15] ? 32'(-33'(ent_in.a_den)) : 32'(ent_in.a_den);
              gsh     <= 5'd0;
              res_num <= 16'sd0;
              res_den <= 15'd1;
              status  <= ST_OK;
              if (ent_in.a_den == 16'sd0) begin
                status <= ST_ZERO;
              end else if (ent_in.exponent == 8'sd0) begin
                res_num <= 16'sd1;
              end else if (ent_in.a_num == 16'sd0 && ent_in.exponent[7]) begin
                status <= ST_ZERO;
              end
            end
            CLS_NONE: begin
              res_num <= 16'sd0;
              res_den <= 15'd1;
              status  <= ST_OK;
            end
            default: begin
            end
          endcase
        end
      end
      B_MUL: begin
        p0 <= ent.a_num * mop0;
        p1 <= ent.a_den * ent.b_num;
        p2 <= ent.a_den * mop2;
      end
      B_SUM: begin
        unique case (ent.op)
          OP_ADD:  n <= 33'(p0) + 33'(p1);
          OP_SUB:  n <= 33'(p0) - 33'(p1);
          default: n <= 33'(p0);
        endcase
        d <= 33'(p2);
      end
      B_NORM: begin
        res_num <= 16'sd0;
        res_den <= 15'd1;
        status  <= (d == 33'sd0) ? ST_ZERO : ST_OK;
        neg     <= n[32] ^ d[32];
        gx      <= n[32] ? 32'(-n) : 32'(n);
        gy      <= d[32] ? 32'(-d) : 32'(d);
        qn      <= n[32] ? 32'(-n) : 32'(n);
        qd      <= d[32] ? 32'(-d) : 32'(d);
        gsh     <= 5'd0;
      end
      B_GCD: begin
        if (gcd_done) begin
          gdiv  <= g;
          rem_n <= 32'd0;
          rem_d <= 32'd0;
          cnt   <= 5'd31;
        end else if (!gx[0] && !gy[0]) begin
          gx  <= gx >> 1;
          gy  <= gy >> 1;
          gsh <= gsh + 5'd1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx >= gy) begin
          gx <= gx - gy;
        end else begin
          gy <= gy - gx;
        end
      end
      B_DIV: begin
        // one quotient bit per cycle for both parts
        if (sh_n >= {1'b0, gdiv}) begin
          rem_n <= 32'(sh_n - {1'b0, gdiv});
          qn    <= {qn[30:0], 1'b1};
        end else begin
          rem_n <= sh_n[31:0];
          qn    <= {qn[30:0], 1'b0};
        end
        if (sh_d >= {1'b0, gdiv}) begin
          rem_d <= 32'(sh_d - {1'b0, gdiv});
          qd    <= {qd[30:0], 1'b1};
        end else begin
          rem_d <= sh_d[31:0];
          qd    <= {qd[30:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
      end
      B_PREP: begin
        // a negative exponent inverts the reduced base
        base_n <= ent.exponent[7] ? qd[15:0] : qn[15:0];
        base_d <= ent.exponent[7] ? qn[15:0] : qd[15:0];
        pw_n   <= 32'd1;
        pw_d   <= 32'd1;
        pcnt   <= kmag;
        if (!kmag[0]) begin
          neg <= 1'b0;
        end
      end
      B_POW: begin
        if (pow_over) begin
          res_num <= 16'sd0;
          res_den <= 15'd1;
          status  <= ST_OVF;
        end else if (pcnt == 8'd0) begin
          pow_pre <= 1'b0;
          n       <= neg ? -33'({1'b0, pw_n}) : 33'({1'b0, pw_n});
          d       <= 33'({1'b0, pw_d});
        end else begin
          pw_n <= pw_n[15:0] * base_n;
          pw_d <= pw_d[15:0] * base_d;
          pcnt <= pcnt - 8'd1;
        end
      end
      B_CHECK: begin
        if (qd > LIM - 32'd1 || (neg ? qn > LIM : qn > LIM - 32'd1)) begin
          res_num <= 16'sd0;
          res_den <= 15'd1;
          status  <= ST_OVF;
        end else begin
          res_num <= neg ? 16'(-qn) : 16'(qn);
          res_den <= qd[14:0];
          status  <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // result register, freed by a transfer on the output channel
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == B_EMIT && emit_go) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EMIT && emit_go) begin
      rsp.res_num <= res_num;
      rsp.res_den <= res_den;
      rsp.status  <= status;
    end
  end

endmodule
